[rtl/cantx_pkg.sv]
`default_nettype none

package cantx_pkg;

    // Mailbox bank
    localparam int unsigned NUM_MAILBOXES = 3;
    localparam int unsigned MB_W          = 2;

    // Frame field widths
    localparam int unsigned ID_W   = 29;
    localparam int unsigned LEN_W  = 4;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned LVL_W  = 4;

    // Stream payload widths, padded to whole bytes
    localparam int unsigned IN_TDATA_W  = 104;
    localparam int unsigned OUT_TDATA_W = 112;

    // Request kinds carried on s_tuser
    typedef enum logic {
        KIND_ENQUEUE = 1'b0,
        KIND_DONE    = 1'b1
    } kind_t;

    // One queued frame
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } frame_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_READ,
        ST_SCAN,
        ST_COMMIT
    } state_t;

endpackage

`default_nettype wire

[rtl/can_tx_mailbox_scheduler.sv]
`default_nettype none
// CAN transmit mailbox scheduler.
// Input stream (s_*): one request per handshake. s_tuser is the kind: enqueue a
// frame, or report that a mailbox finished sending. s_tdata carries the frame
// fields and the completed mailbox index.
// Output stream (m_*): exactly one result per request, in request order: the
// load (mailbox, id, length, data; zero when nothing was loaded), the
// blocked and dropped flags, the queue level and the busy summary.
// Frames wait in a ring queue of QUEUE_DEPTH entries; the head frame goes to
// the lowest free mailbox unless an occupied mailbox holds an id less than or
// equal to it.
// Sequence: a request passes through apply, read and commit when no load is
// attempted (queue empty or no mailbox free), and through apply, read, scan
// and commit when a load is attempted, since one shared identifier comparator
// walks the three mailboxes one per cycle. s_tready returns in the same cycle
// as m_tvalid, so a request is taken only once the last one has left commit.
// A stalled receiver holds the result register; the block still takes the
// next request and runs it up to the point of writing its result, where it
// waits for the register to drain.
// Reset (aresetn low, synchronous) empties the queue and frees all mailboxes.
module can_tx_mailbox_scheduler #(
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // frame_id[28:0], frame_len[32:29], frame_data[96:33], done_mailbox[98:97]
    input  wire logic [cantx_pkg::IN_TDATA_W-1:0]   s_tdata,
    // kind[0]
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // loaded[0], load_mailbox[2:1], load_id[31:3], load_len[35:32],
    // load_data[99:36], blocked[100], dropped[101], queue_level[105:102],
    // tx_busy[106]
    output logic [cantx_pkg::OUT_TDATA_W-1:0]       m_tdata
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // Sequencer
    cantx_pkg::state_t state_reg, state_next;

    // Latched request
    cantx_pkg::kind_t  kind_reg;
    cantx_pkg::frame_t req_reg;
    logic [cantx_pkg::MB_W-1:0] done_reg;

    // Ring queue
    cantx_pkg::frame_t queue_mem [QUEUE_DEPTH];
    cantx_pkg::frame_t head_reg;
    logic [PTR_W-1:0]  head_ptr_reg, tail_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    // Mailboxes
    logic [cantx_pkg::NUM_MAILBOXES-1:0] busy_reg;
    logic [cantx_pkg::ID_W-1:0]          mb_id_reg [cantx_pkg::NUM_MAILBOXES];

    // Per-request working state
    logic                       drop_reg;
    logic                       attempt_reg;
    logic                       refuse_reg;
    logic [cantx_pkg::MB_W-1:0] free_idx_reg;
    logic [cantx_pkg::MB_W-1:0] scan_idx_reg;

    // Output register
    logic                                m_tvalid_reg;
    logic [cantx_pkg::OUT_TDATA_W-1:0]   m_tdata_reg;

    // Controls decoded from state
    logic in_take, apply_en, read_en, scan_en, commit_wait, commit_go;

    // Free mailbox search, first free from mailbox 0 up
    logic                       free_found;
    logic [cantx_pkg::MB_W-1:0] free_idx;

    // Shared comparator: does the scanned mailbox block the head frame
    logic                       scan_block;
    logic                       scan_last;

    // Commit arithmetic
    logic                                 do_load;
    logic [CNT_W-1:0]                     count_after;
    logic [cantx_pkg::NUM_MAILBOXES-1:0]  busy_after;
    logic [cantx_pkg::LVL_W-1:0]          level_after;
    logic                                 queue_full;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cantx_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = cantx_pkg::ST_APPLY;
                end
            end
            cantx_pkg::ST_APPLY: begin
                state_next = cantx_pkg::ST_READ;
            end
            cantx_pkg::ST_READ: begin
                if ((count_reg != '0) && free_found) begin
                    state_next = cantx_pkg::ST_SCAN;
                end else begin
                    state_next = cantx_pkg::ST_COMMIT;
                end
            end
            cantx_pkg::ST_SCAN: begin
                if (scan_last) begin
                    state_next = cantx_pkg::ST_COMMIT;
                end
            end
            cantx_pkg::ST_COMMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = cantx_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cantx_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        in_take     = 1'b0;
        apply_en    = 1'b0;
        read_en     = 1'b0;
        scan_en     = 1'b0;
        commit_wait = 1'b0;
        case (state_reg)
            cantx_pkg::ST_IDLE:   in_take     = 1'b1;
            cantx_pkg::ST_APPLY:  apply_en    = 1'b1;
            cantx_pkg::ST_READ:   read_en     = 1'b1;
            cantx_pkg::ST_SCAN:   scan_en     = 1'b1;
            cantx_pkg::ST_COMMIT: commit_wait = 1'b1;
            default:              in_take     = 1'b0;
        endcase
    end

    assign s_tready  = in_take;
    assign commit_go = commit_wait && (!m_tvalid_reg || m_tready);

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = cantx_pkg::NUM_MAILBOXES - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_found = 1'b1;
                free_idx   = cantx_pkg::MB_W'(i);
            end
        end
    end

    assign scan_block = busy_reg[scan_idx_reg] && (mb_id_reg[scan_idx_reg] <= head_reg.id);
    assign scan_last  = (scan_idx_reg == cantx_pkg::MB_W'(cantx_pkg::NUM_MAILBOXES - 1));

    assign queue_full = (count_reg == CNT_FULL);
    assign do_load    = attempt_reg && !refuse_reg;

    always_comb begin
        count_after = count_reg;
        busy_after  = busy_reg;
        if (do_load) begin
            count_after = count_reg - CNT_W'(1);
            busy_after[free_idx_reg] = 1'b1;
        end
        if (32'(count_after) > 32'd15) begin
            level_after = cantx_pkg::LVL_W'(15);
        end else begin
            level_after = cantx_pkg::LVL_W'(count_after);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cantx_pkg::ST_IDLE;
            head_ptr_reg <= '0;
            tail_ptr_reg <= '0;
            count_reg    <= '0;
            busy_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Apply the event: append a frame or free a mailbox
            if (apply_en) begin
                if (kind_reg == cantx_pkg::KIND_ENQUEUE) begin
                    if (!queue_full) begin
                        tail_ptr_reg <= (tail_ptr_reg == PTR_LAST) ? '0
                                                                   : tail_ptr_reg + PTR_W'(1);
                        count_reg    <= count_reg + CNT_W'(1);
                    end
                end else if (32'(done_reg) < cantx_pkg::NUM_MAILBOXES) begin
                    busy_reg[done_reg] <= 1'b0;
                end
            end

            // Load the head frame, advance the head
            if (commit_go && do_load) begin
                busy_reg     <= busy_after;
                count_reg    <= count_after;
                head_ptr_reg <= (head_ptr_reg == PTR_LAST) ? '0 : head_ptr_reg + PTR_W'(1);
            end

            if (commit_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Queue storage: write on enqueue, registered read of the head
    always_ff @(posedge aclk) begin
        if (apply_en && (kind_reg == cantx_pkg::KIND_ENQUEUE) && !queue_full) begin
            queue_mem[tail_ptr_reg] <= req_reg;
        end
        if (read_en) begin
            head_reg <= queue_mem[head_ptr_reg];
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && in_take) begin
            kind_reg     <= cantx_pkg::kind_t'(s_tuser);
            req_reg.id   <= s_tdata[28:0];
            req_reg.len  <= s_tdata[32:29];
            req_reg.data <= s_tdata[96:33];
            done_reg     <= s_tdata[98:97];
        end

        if (apply_en) begin
            drop_reg <= (kind_reg == cantx_pkg::KIND_ENQUEUE) && queue_full;
        end

        // Set up the scan: attempt only with a frame waiting and a free mailbox
        if (read_en) begin
            attempt_reg  <= (count_reg != '0) && free_found;
            free_idx_reg <= free_idx;
            refuse_reg   <= 1'b0;
            scan_idx_reg <= '0;
        end

        // One mailbox per cycle through the shared comparator
        if (scan_en) begin
            refuse_reg <= refuse_reg | scan_block;
            if (!scan_last) begin
                scan_idx_reg <= scan_idx_reg + cantx_pkg::MB_W'(1);
            end
        end

        if (commit_go && do_load) begin
            mb_id_reg[free_idx_reg] <= head_reg.id;
        end

        if (commit_go) begin
            m_tdata_reg <= {
                5'd0,
                (count_after != '0) || (|busy_after),
                level_after,
                drop_reg,
                attempt_reg && refuse_reg,
                do_load ? head_reg.data : {cantx_pkg::DATA_W{1'b0}},
                do_load ? head_reg.len  : {cantx_pkg::LEN_W{1'b0}},
                do_load ? head_reg.id   : {cantx_pkg::ID_W{1'b0}},
                do_load ? free_idx_reg  : {cantx_pkg::MB_W{1'b0}},
                do_load
            };
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The queue never holds more frames than it has entries
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");

    // The level moves by at most one frame per cycle
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CNT_W'(1))
        || (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("queue count jumped");

    // A load always targets a mailbox that is free
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit_go && do_load) |-> !busy_reg[free_idx_reg])
        else $error("load into an occupied mailbox");

    // A result never reports both a load and a refusal
    a_load_xor_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[0] && m_tdata_reg[100]))
        else $error("loaded and blocked together");

    // After a request is taken the block does not take another right away
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while busy");

endmodule

`default_nettype wire
